// ===== hdl/tssc_pkg.sv =====
package tssc_pkg;

    localparam int unsigned SEQ_W = 48;
    localparam int unsigned ABS_W = 32;
    localparam int unsigned PAY_W = 16;
    localparam int unsigned CNT_W = 32;
    localparam int unsigned SUM_W = 48;

    // SYN re-base window on the absolute sequence number
    localparam logic [ABS_W-1:0] SYN_MOVE_LIMIT = 32'd10;

    typedef enum logic [2:0] {
        CLS_ACK     = 3'd0,
        CLS_NEW     = 3'd1,
        CLS_BUNDLE  = 3'd2,
        CLS_RETRANS = 3'd3,
        CLS_IGNORED = 3'd4
    } t_seg_class;

    typedef struct packed {
        logic [SEQ_W-1:0] seg_start;
        logic [SEQ_W-1:0] seg_end;
        logic [ABS_W-1:0] seg_start_absolute;
        logic [PAY_W-1:0] payload_bytes;
        logic             syn_flag;
    } t_seg;

    typedef struct packed {
        logic             accepted;
        t_seg_class       seg_class;
        logic [SEQ_W-1:0] bundle_old_end;
        logic [CNT_W-1:0] packets_seen;
        logic [CNT_W-1:0] data_packets;
        logic [CNT_W-1:0] retrans_packets;
        logic [CNT_W-1:0] bundle_packets;
        logic [CNT_W-1:0] ignored_packets;
        logic [SUM_W-1:0] bytes_total;
        logic [SUM_W-1:0] bytes_new;
        logic [SUM_W-1:0] bytes_redundant;
        logic [SUM_W-1:0] bytes_retrans;
    } t_result;

    // saturating counter increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + CNT_W'(1);
    endfunction

    // saturating 48-bit accumulate
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                input logic [SUM_W-1:0] a);
        logic [SUM_W:0] sum;
        sum = {1'b0, s} + {1'b0, a};
        return sum[SUM_W] ? '1 : sum[SUM_W-1:0];
    endfunction

endpackage

// ===== hdl/tssc_in_reg.sv =====
module tssc_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  tssc_pkg::t_seg i_seg,
    input  logic          i_advance,
    output logic          o_stall,
    output logic          o_valid,
    output tssc_pkg::t_seg o_seg
);
    import tssc_pkg::*;

    logic r_valid;
    t_seg r_seg;
    logic n_load;

    // stage empties when its transaction moves on
    assign n_load  = !r_valid || i_advance;
    assign o_stall = !n_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load && i_valid) begin
            r_seg <= i_seg;
        end
    end

    assign o_valid = r_valid;
    assign o_seg   = r_seg;

endmodule

// ===== hdl/tssc_classify.sv =====
module tssc_classify (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  tssc_pkg::t_seg             i_seg,
    input  logic                       i_cfg_wr_en,
    input  logic [tssc_pkg::ABS_W-1:0] i_cfg_wr_data,
    output tssc_pkg::t_result          o_res
);
    import tssc_pkg::*;

    // stream state
    logic [SEQ_W-1:0] r_largest_end, r_last_start;
    logic [ABS_W-1:0] r_first_abs_seq;
    logic             r_closed;
    logic [CNT_W-1:0] r_cnt_packets, r_cnt_data, r_cnt_retrans, r_cnt_bundle;
    logic [CNT_W-1:0] r_cnt_ignored;
    logic [SUM_W-1:0] r_sum_bytes, r_sum_new, r_sum_redundant, r_sum_retrans;

    logic [SEQ_W-1:0] n_largest_end, n_last_start;
    logic [ABS_W-1:0] n_first_abs_seq;
    logic             n_closed;
    logic [CNT_W-1:0] n_cnt_packets, n_cnt_data, n_cnt_retrans, n_cnt_bundle;
    logic [CNT_W-1:0] n_cnt_ignored;
    logic [SUM_W-1:0] n_sum_bytes, n_sum_new, n_sum_redundant, n_sum_retrans;

    logic             jump, ignore, syn_jump, far, rebase, has_pay, is_new, is_bundle;
    logic [ABS_W-1:0] abs_dist;
    logic [SEQ_W-1:0] start_e, end_e, red_bytes;
    logic [SUM_W-1:0] pay_ext;
    t_seg_class       cls;
    logic [SEQ_W-1:0] old_end;

    // jump detection and SYN handling
    always_comb begin
        jump = (i_seg.seg_end > r_largest_end)
            && ({1'b0, i_seg.seg_start} != ({1'b0, r_largest_end} + (SEQ_W+1)'(1)));
        ignore   = jump && r_closed;
        syn_jump = jump && !r_closed && i_seg.syn_flag;
        abs_dist = (i_seg.seg_start_absolute >= r_first_abs_seq)
                 ? i_seg.seg_start_absolute - r_first_abs_seq
                 : r_first_abs_seq - i_seg.seg_start_absolute;
        far      = abs_dist > SYN_MOVE_LIMIT;
        rebase   = syn_jump && !far;
        start_e  = rebase ? '0 : i_seg.seg_start;
        end_e    = rebase ? '0 : i_seg.seg_end;
    end

    // classification
    always_comb begin
        has_pay   = i_seg.payload_bytes != '0;
        pay_ext   = {{(SUM_W-PAY_W){1'b0}}, i_seg.payload_bytes};
        is_new    = end_e > r_largest_end;
        is_bundle = ((start_e == r_last_start) && ((r_last_start | r_largest_end) != '0))
                 || (start_e < r_largest_end);
        red_bytes = (start_e < r_largest_end) ? r_largest_end - start_e : '0;
    end

    // next state and result
    always_comb begin
        n_largest_end   = r_largest_end;
        n_last_start    = r_last_start;
        n_first_abs_seq = rebase ? i_seg.seg_start_absolute : r_first_abs_seq;
        n_closed        = r_closed || (syn_jump && far);
        n_cnt_packets   = sat_inc(r_cnt_packets);
        n_cnt_data      = r_cnt_data;
        n_cnt_retrans   = r_cnt_retrans;
        n_cnt_bundle    = r_cnt_bundle;
        n_cnt_ignored   = r_cnt_ignored;
        n_sum_bytes     = r_sum_bytes;
        n_sum_new       = r_sum_new;
        n_sum_redundant = r_sum_redundant;
        n_sum_retrans   = r_sum_retrans;
        old_end         = '0;
        cls             = CLS_ACK;

        if (ignore) begin
            n_cnt_ignored = sat_inc(r_cnt_ignored);
            cls           = CLS_IGNORED;
        end else if (has_pay) begin
            if (is_new) begin
                if (is_bundle) begin
                    n_cnt_bundle    = sat_inc(r_cnt_bundle);
                    n_sum_redundant = sat_add(r_sum_redundant, red_bytes);
                    n_sum_new       = sat_add(r_sum_new, end_e - r_largest_end);
                    old_end         = r_largest_end;
                    cls             = CLS_BUNDLE;
                end else begin
                    n_sum_new = sat_add(r_sum_new, pay_ext);
                    cls       = CLS_NEW;
                end
                n_largest_end = end_e;
            end else begin
                n_cnt_retrans = sat_inc(r_cnt_retrans);
                n_sum_retrans = sat_add(r_sum_retrans, pay_ext);
                cls           = CLS_RETRANS;
            end
            n_cnt_data   = sat_inc(r_cnt_data);
            n_last_start = start_e;
            n_sum_bytes  = sat_add(r_sum_bytes, pay_ext);
        end
    end

    always_comb begin
        o_res.accepted        = !ignore;
        o_res.seg_class       = cls;
        o_res.bundle_old_end  = old_end;
        o_res.packets_seen    = n_cnt_packets;
        o_res.data_packets    = n_cnt_data;
        o_res.retrans_packets = n_cnt_retrans;
        o_res.bundle_packets  = n_cnt_bundle;
        o_res.ignored_packets = n_cnt_ignored;
        o_res.bytes_total     = n_sum_bytes;
        o_res.bytes_new       = n_sum_new;
        o_res.bytes_redundant = n_sum_redundant;
        o_res.bytes_retrans   = n_sum_retrans;
    end

    // state update on each transaction; config loads the first sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_largest_end   <= '0;
            r_last_start    <= '0;
            r_first_abs_seq <= '0;
            r_closed        <= 1'b0;
            r_cnt_packets   <= '0;
            r_cnt_data      <= '0;
            r_cnt_retrans   <= '0;
            r_cnt_bundle    <= '0;
            r_cnt_ignored   <= '0;
            r_sum_bytes     <= '0;
            r_sum_new       <= '0;
            r_sum_redundant <= '0;
            r_sum_retrans   <= '0;
        end else if (i_cfg_wr_en) begin
            r_first_abs_seq <= i_cfg_wr_data;
        end else if (i_fire) begin
            r_largest_end   <= n_largest_end;
            r_last_start    <= n_last_start;
            r_first_abs_seq <= n_first_abs_seq;
            r_closed        <= n_closed;
            r_cnt_packets   <= n_cnt_packets;
            r_cnt_data      <= n_cnt_data;
            r_cnt_retrans   <= n_cnt_retrans;
            r_cnt_bundle    <= n_cnt_bundle;
            r_cnt_ignored   <= n_cnt_ignored;
            r_sum_bytes     <= n_sum_bytes;
            r_sum_new       <= n_sum_new;
            r_sum_redundant <= n_sum_redundant;
            r_sum_retrans   <= n_sum_retrans;
        end
    end

endmodule

// ===== hdl/tssc_out_reg.sv =====
module tssc_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  tssc_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_advance,
    output logic              o_valid,
    output tssc_pkg::t_result o_res
);
    import tssc_pkg::*;

    logic    r_valid;
    t_result r_res;

    // result slot is free when empty or being taken this cycle
    assign o_advance = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== hdl/tcp_sent_segment_classifier.sv =====
// Accepted segments pass the input register, then the result register, to the outputs.
// Throughput: one segment per cycle while the output is not stalled; the stream state
// updates in a single pass between the input register and the result register.
// Input stall rises only while both registers hold and the output is stalled.
// Reset (synchronous, active low) clears both stages, the stream state and all
// counters and sums; first_abs_seq returns to 0 until written or re-based by a SYN.
module tcp_sent_segment_classifier (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // config
    input  logic                       i_cfg_wr_en,
    input  logic [tssc_pkg::ABS_W-1:0] i_cfg_wr_data,
    // segment in
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [tssc_pkg::SEQ_W-1:0] i_seg_start,
    input  logic [tssc_pkg::SEQ_W-1:0] i_seg_end,
    input  logic [tssc_pkg::ABS_W-1:0] i_seg_start_absolute,
    input  logic [tssc_pkg::PAY_W-1:0] i_payload_bytes,
    input  logic                       i_syn_flag,
    // result out
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_accepted,
    output logic [2:0]                 o_seg_class,
    output logic [tssc_pkg::SEQ_W-1:0] o_bundle_old_end,
    output logic [tssc_pkg::CNT_W-1:0] o_packets_seen,
    output logic [tssc_pkg::CNT_W-1:0] o_data_packets,
    output logic [tssc_pkg::CNT_W-1:0] o_retrans_packets,
    output logic [tssc_pkg::CNT_W-1:0] o_bundle_packets,
    output logic [tssc_pkg::CNT_W-1:0] o_ignored_packets,
    output logic [tssc_pkg::SUM_W-1:0] o_bytes_total,
    output logic [tssc_pkg::SUM_W-1:0] o_bytes_new,
    output logic [tssc_pkg::SUM_W-1:0] o_bytes_redundant,
    output logic [tssc_pkg::SUM_W-1:0] o_bytes_retrans
);
    import tssc_pkg::*;

    t_seg    w_seg_in, w_seg_s1;
    t_result w_res_next, w_res_out;
    logic    w_s1_valid, w_advance, w_fire;

    assign w_seg_in.seg_start          = i_seg_start;
    assign w_seg_in.seg_end            = i_seg_end;
    assign w_seg_in.seg_start_absolute = i_seg_start_absolute;
    assign w_seg_in.payload_bytes      = i_payload_bytes;
    assign w_seg_in.syn_flag           = i_syn_flag;

    // stage 1 transaction moves to the result register
    assign w_fire = w_s1_valid && w_advance;

    tssc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_seg     (w_seg_in),
        .i_advance (w_advance),
        .o_stall   (o_stall),
        .o_valid   (w_s1_valid),
        .o_seg     (w_seg_s1)
    );

    tssc_classify u_classify (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_seg         (w_seg_s1),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_res         (w_res_next)
    );

    tssc_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_res     (w_res_next),
        .i_stall   (i_stall),
        .o_advance (w_advance),
        .o_valid   (o_valid),
        .o_res     (w_res_out)
    );

    assign o_accepted        = w_res_out.accepted;
    assign o_seg_class       = w_res_out.seg_class;
    assign o_bundle_old_end  = w_res_out.bundle_old_end;
    assign o_packets_seen    = w_res_out.packets_seen;
    assign o_data_packets    = w_res_out.data_packets;
    assign o_retrans_packets = w_res_out.retrans_packets;
    assign o_bundle_packets  = w_res_out.bundle_packets;
    assign o_ignored_packets = w_res_out.ignored_packets;
    assign o_bytes_total     = w_res_out.bytes_total;
    assign o_bytes_new       = w_res_out.bytes_new;
    assign o_bytes_redundant = w_res_out.bytes_redundant;
    assign o_bytes_retrans   = w_res_out.bytes_retrans;

    // a transaction leaving stage 1 always lands in the result register
    a_fire_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_valid)
        else $error("stage 1 transaction lost");

    // consecutive results count exactly one more packet unless saturated
    a_pkt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) ##1 o_valid |->
            (o_packets_seen == $past(o_packets_seen) + CNT_W'(1))
            || ($past(o_packets_seen) == '1))
        else $error("packet count skipped or repeated");

    // ignored class and accepted flag agree
    a_ignore_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_accepted == (o_seg_class != CLS_IGNORED)))
        else $error("accepted flag does not match class");

    // old end is reported for bundles only
    a_old_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_seg_class != CLS_BUNDLE)) |-> (o_bundle_old_end == '0))
        else $error("old end set on non-bundle result");

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tssc_pkg::*;

    localparam int unsigned     PIPE_LAT    = 2;
    localparam longint unsigned CYCLE_LIMIT = 1_000_000;
    localparam logic [SEQ_W-1:0] SEQ_MAX  = '1;
    localparam logic [SEQ_W-1:0] SEQ_HALF = 48'h8000_0000_0000;
    localparam logic [ABS_W-1:0] ABS_MAX  = '1;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [ABS_W-1:0] i_cfg_wr_data;
    logic             i_valid;
    logic             o_stall;
    logic [SEQ_W-1:0] i_seg_start;
    logic [SEQ_W-1:0] i_seg_end;
    logic [ABS_W-1:0] i_seg_start_absolute;
    logic [PAY_W-1:0] i_payload_bytes;
    logic             i_syn_flag;
    logic             o_valid;
    logic             i_stall;
    logic             o_accepted;
    logic [2:0]       o_seg_class;
    logic [SEQ_W-1:0] o_bundle_old_end;
    logic [CNT_W-1:0] o_packets_seen;
    logic [CNT_W-1:0] o_data_packets;
    logic [CNT_W-1:0] o_retrans_packets;
    logic [CNT_W-1:0] o_bundle_packets;
    logic [CNT_W-1:0] o_ignored_packets;
    logic [SUM_W-1:0] o_bytes_total;
    logic [SUM_W-1:0] o_bytes_new;
    logic [SUM_W-1:0] o_bytes_redundant;
    logic [SUM_W-1:0] o_bytes_retrans;

    tcp_sent_segment_classifier dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_wr_data        (i_cfg_wr_data),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_seg_start          (i_seg_start),
        .i_seg_end            (i_seg_end),
        .i_seg_start_absolute (i_seg_start_absolute),
        .i_payload_bytes      (i_payload_bytes),
        .i_syn_flag           (i_syn_flag),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_accepted           (o_accepted),
        .o_seg_class          (o_seg_class),
        .o_bundle_old_end     (o_bundle_old_end),
        .o_packets_seen       (o_packets_seen),
        .o_data_packets       (o_data_packets),
        .o_retrans_packets    (o_retrans_packets),
        .o_bundle_packets     (o_bundle_packets),
        .o_ignored_packets    (o_ignored_packets),
        .o_bytes_total        (o_bytes_total),
        .o_bytes_new          (o_bytes_new),
        .o_bytes_redundant    (o_bytes_redundant),
        .o_bytes_retrans      (o_bytes_retrans)
    );

    // predicted stream state
    logic [SEQ_W-1:0] hi_end;
    logic [SEQ_W-1:0] prev_start;
    logic [ABS_W-1:0] base_seq;
    logic             stream_closed;
    logic [CNT_W-1:0] n_seen, n_data, n_retx, n_bundle, n_ignored;
    logic [SUM_W-1:0] b_total, b_new, b_redund, b_retx;

    t_result         class_queue[$];
    int unsigned     err_count;
    longint unsigned cycles;
    bit              in_idle_en;
    bit              out_idle_en;
    int unsigned     stall_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        logic [CNT_W:0] w;
        w = {1'b0, c} + 1'b1;
        return w[CNT_W] ? c : w[CNT_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] accum(input logic [SUM_W-1:0] s,
                                               input logic [SUM_W-1:0] a);
        logic [SUM_W:0] w;
        w = {1'b0, s} + {1'b0, a};
        if (w[SUM_W])
            return '1;
        return w[SUM_W-1:0];
    endfunction

    // advance the predicted state by one segment and return its result
    function automatic t_result classify_segment(input t_seg s);
        t_result          r;
        logic [SEQ_W-1:0] st, en, red;
        logic [ABS_W-1:0] abs_gap;
        logic             jump_ahead, overlap;
        st = s.seg_start;
        en = s.seg_end;
        r = '0;
        r.accepted = 1'b1;
        n_seen = bump(n_seen);

        jump_ahead = (en > hi_end) && ({1'b0, st} != {1'b0, hi_end} + 1'b1);
        if (jump_ahead) begin
            if (stream_closed) begin
                n_ignored = bump(n_ignored);
                r.accepted = 1'b0;
            end else if (s.syn_flag) begin
                abs_gap = (s.seg_start_absolute >= base_seq) ?
                          s.seg_start_absolute - base_seq : base_seq - s.seg_start_absolute;
                if (abs_gap > SYN_MOVE_LIMIT) begin
                    stream_closed = 1'b1;
                end else begin
                    // re-base: stream restarts at relative zero
                    base_seq = s.seg_start_absolute;
                    st = '0;
                    en = '0;
                end
            end
        end

        if (!r.accepted) begin
            r.seg_class = CLS_IGNORED;
        end else if (s.payload_bytes == '0) begin
            r.seg_class = CLS_ACK;
        end else begin
            if (en > hi_end) begin
                overlap = (st == prev_start && (prev_start | hi_end) != '0) || st < hi_end;
                if (overlap) begin
                    red = (st < hi_end) ? hi_end - st : '0;
                    n_bundle = bump(n_bundle);
                    b_redund = accum(b_redund, red);
                    b_new = accum(b_new, en - hi_end);
                    r.bundle_old_end = hi_end;
                    r.seg_class = CLS_BUNDLE;
                end else begin
                    b_new = accum(b_new, SUM_W'(s.payload_bytes));
                    r.seg_class = CLS_NEW;
                end
                hi_end = en;
            end else begin
                n_retx = bump(n_retx);
                b_retx = accum(b_retx, SUM_W'(s.payload_bytes));
                r.seg_class = CLS_RETRANS;
            end
            n_data = bump(n_data);
            prev_start = st;
            b_total = accum(b_total, SUM_W'(s.payload_bytes));
        end

        r.packets_seen    = n_seen;
        r.data_packets    = n_data;
        r.retrans_packets = n_retx;
        r.bundle_packets  = n_bundle;
        r.ignored_packets = n_ignored;
        r.bytes_total     = b_total;
        r.bytes_new       = b_new;
        r.bytes_redundant = b_redund;
        r.bytes_retrans   = b_retx;
        return r;
    endfunction

    function automatic t_seg mk_seg(input logic [SEQ_W-1:0] st, input logic [SEQ_W-1:0] en,
                                    input logic [ABS_W-1:0] abs, input logic [PAY_W-1:0] pay,
                                    input logic syn);
        t_seg s;
        s.seg_start          = st;
        s.seg_end            = en;
        s.seg_start_absolute = abs;
        s.payload_bytes      = pay;
        s.syn_flag           = syn;
        return s;
    endfunction

    function automatic logic [SEQ_W-1:0] back_off(input logic [SEQ_W-1:0] v,
                                                  input logic [SEQ_W-1:0] d);
        return (v > d) ? v - d : '0;
    endfunction

    // absolute sequence within delta of the current base, clamped to 32 bits
    function automatic logic [ABS_W-1:0] near_base(input int delta);
        longint v;
        v = longint'(base_seq) + delta;
        if (v < 0)
            v = 0;
        if (v > longint'(ABS_MAX))
            v = longint'(ABS_MAX);
        return ABS_W'(v);
    endfunction

    // keep new-byte sum at or above the largest end, so the late jump to the
    // top of the sequence space drives it into saturation
    function automatic t_seg cover_advance(input t_seg s);
        logic [SEQ_W-1:0] adv;
        adv = s.seg_end - hi_end;
        if (s.seg_end > hi_end && s.payload_bytes != '0 && adv <= SEQ_W'(16'hFFFF)
            && adv > SEQ_W'(s.payload_bytes))
            s.payload_bytes = PAY_W'(adv);
        return s;
    endfunction

    function automatic logic [SEQ_W-1:0] rand_seq();
        return SEQ_W'({$urandom, $urandom});
    endfunction

    // segment mix for an open stream: syn jumps stay inside the re-base window
    function automatic t_seg gen_open_seg();
        logic [SEQ_W-1:0] st, en, adv;
        logic [ABS_W-1:0] abs;
        logic [PAY_W-1:0] pay;
        logic             syn;
        int unsigned      pick;
        pick = $urandom_range(0, 99);
        abs  = $urandom;
        syn  = 1'b0;
        pay  = PAY_W'($urandom_range(1, 1500));
        if (pick < 35) begin
            st  = hi_end + 1'b1;
            adv = SEQ_W'($urandom_range(1, 2000));
            en  = st + adv - 1'b1;
            pay = PAY_W'(adv + $urandom_range(0, 50));
        end else if (pick < 55) begin
            en = back_off(hi_end, SEQ_W'($urandom_range(0, 3000)));
            if ($urandom_range(0, 7) == 0)
                st = en + $urandom_range(1, 10);
            else
                st = back_off(en, SEQ_W'($urandom_range(0, 1500)));
        end else if (pick < 70) begin
            st = back_off(hi_end, SEQ_W'($urandom_range(0, 3000)));
            en = hi_end + $urandom_range(1, 2000);
        end else if (pick < 75) begin
            st = prev_start;
            en = ((prev_start > hi_end) ? prev_start : hi_end) + $urandom_range(1, 2000);
        end else if (pick < 85) begin
            syn = 1'b1;
            st  = hi_end + $urandom_range(2, 500);
            en  = st + $urandom_range(0, 500);
            abs = near_base(int'($urandom_range(0, 20)) - 10);
            if ($urandom_range(0, 3) == 0)
                pay = '0;
        end else if (pick < 95) begin
            st  = back_off(hi_end, SEQ_W'($urandom_range(0, 65535))) + $urandom_range(0, 65535);
            en  = back_off(hi_end, SEQ_W'($urandom_range(0, 65535))) + $urandom_range(0, 65535);
            pay = PAY_W'($urandom);
            syn = 1'($urandom_range(0, 1));
            if (syn)
                abs = near_base(int'($urandom_range(0, 20)) - 10);
        end else begin
            st  = hi_end + $urandom_range(0, 3);
            en  = st + $urandom_range(0, 100);
            pay = '0;
        end
        return cover_advance(mk_seg(st, en, abs, pay, syn));
    endfunction

    // segment mix once the stream is closed: full-width noise plus in-order traffic
    function automatic t_seg gen_closed_seg();
        logic [SEQ_W-1:0] st, en, adv;
        logic [ABS_W-1:0] abs;
        logic [PAY_W-1:0] pay;
        logic             syn;
        int unsigned      pick;
        pick = $urandom_range(0, 99);
        abs  = $urandom;
        syn  = 1'($urandom_range(0, 1));
        pay  = PAY_W'($urandom_range(1, 1500));
        if (pick < 35) begin
            st  = rand_seq();
            en  = rand_seq();
            pay = PAY_W'($urandom);
        end else if (pick < 60) begin
            st  = hi_end + 1'b1;
            adv = SEQ_W'($urandom_range(1, 2000));
            en  = st + adv - 1'b1;
            pay = PAY_W'(adv + $urandom_range(0, 50));
        end else if (pick < 72) begin
            en = back_off(hi_end, SEQ_W'($urandom_range(0, 3000)));
            st = rand_seq();
        end else if (pick < 82) begin
            // retransmission parked just past the end: next in-order one bundles
            st = hi_end + 1'b1;
            en = back_off(hi_end, SEQ_W'($urandom_range(0, 100)));
        end else if (pick < 95) begin
            st  = hi_end + $urandom_range(2, 500);
            en  = st + $urandom_range(0, 500);
            abs = near_base(int'($urandom_range(0, 20)) - 10);
        end else begin
            st  = hi_end + 1'b1;
            en  = st + $urandom_range(0, 100);
            pay = '0;
        end
        return cover_advance(mk_seg(st, en, abs, pay, syn));
    endfunction

    // drive one segment and wait for its transaction; called at a falling edge
    task automatic send_seg(input t_seg s);
        int unsigned gap;
        if (in_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid              <= 1'b1;
        i_seg_start          <= s.seg_start;
        i_seg_end            <= s.seg_end;
        i_seg_start_absolute <= s.seg_start_absolute;
        i_payload_bytes      <= s.payload_bytes;
        i_syn_flag           <= s.syn_flag;
        do @(posedge i_clk); while (o_stall);
        class_queue.insert(class_queue.size(), classify_segment(s));
        @(negedge i_clk);
    endtask

    // stop sending and let every outstanding result come out
    task automatic drain();
        i_valid <= 1'b0;
        while (class_queue.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_LAT + 2) @(negedge i_clk);
    endtask

    task automatic write_base_seq(input logic [ABS_W-1:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        base_seq = v;
        @(negedge i_clk);
    endtask

    task automatic pick_idling();
        in_idle_en  = ($urandom_range(0, 3) != 0);
        out_idle_en = ($urandom_range(0, 3) != 0);
    endtask

    // result stall: random bursts, each of a random length
    initial begin
        i_stall = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (!out_idle_en) begin
                stall_left = 0;
                i_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 18);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic void cmp_field(input string fname, input logic [SUM_W-1:0] want,
                                      input logic [SUM_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            err_count++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (class_queue.size() == 0) begin
                $error("result transaction with no segment outstanding");
                err_count++;
            end else begin
                want = class_queue.pop_front();
                cmp_field("accepted", SUM_W'(want.accepted), SUM_W'(o_accepted));
                cmp_field("seg_class", SUM_W'(want.seg_class), SUM_W'(o_seg_class));
                cmp_field("bundle_old_end", want.bundle_old_end, o_bundle_old_end);
                cmp_field("packets_seen", SUM_W'(want.packets_seen),
                          SUM_W'(o_packets_seen));
                cmp_field("data_packets", SUM_W'(want.data_packets),
                          SUM_W'(o_data_packets));
                cmp_field("retrans_packets", SUM_W'(want.retrans_packets),
                          SUM_W'(o_retrans_packets));
                cmp_field("bundle_packets", SUM_W'(want.bundle_packets),
                          SUM_W'(o_bundle_packets));
                cmp_field("ignored_packets", SUM_W'(want.ignored_packets),
                          SUM_W'(o_ignored_packets));
                cmp_field("bytes_total",     want.bytes_total,     o_bytes_total);
                cmp_field("bytes_new",       want.bytes_new,       o_bytes_new);
                cmp_field("bytes_redundant", want.bytes_redundant, o_bytes_redundant);
                cmp_field("bytes_retrans",   want.bytes_retrans,   o_bytes_retrans);
            end
        end
    end

    // ack, new data, retransmission, bundles, syn re-base at the window edge
    task automatic test_directed_classes();
        send_seg(mk_seg(48'd1, 48'd1, 32'd0, 16'd0, 1'b0));
        send_seg(mk_seg(48'd1, 48'd100, 32'd0, 16'd100, 1'b0));
        send_seg(mk_seg(48'd101, 48'd200, 32'd0, 16'd200, 1'b0));
        send_seg(mk_seg(48'd101, 48'd200, 32'd0, 16'd100, 1'b0));
        // retransmission ahead of the end, then a bundle on the same start
        // (no overlap, so no redundant bytes)
        send_seg(mk_seg(48'd250, 48'd150, 32'd0, 16'd5, 1'b0));
        send_seg(mk_seg(48'd250, 48'd400, 32'd0, 16'd150, 1'b0));
        send_seg(mk_seg(48'd300, 48'd500, 32'd0, 16'd200, 1'b0));
        // syn jump exactly at the window edge, with and without payload
        send_seg(mk_seg(48'd700, 48'd800, 32'd10, 16'd100, 1'b1));
        send_seg(mk_seg(48'd900, 48'd950, 32'd0, 16'd0, 1'b1));
        // syn that is not a jump is plain traffic
        send_seg(mk_seg(48'd501, 48'd600, ABS_MAX, 16'd100, 1'b1));
        send_seg(mk_seg(48'd601, 48'd600, 32'd0, 16'd1, 1'b0));
        send_seg(mk_seg(48'd601, 48'd66135, 32'd0, 16'hFFFF, 1'b0));
        send_seg(mk_seg(48'd66136, 48'd66136, 32'd0, 16'd1, 1'b0));
        send_seg(mk_seg(48'd0, 48'd66146, 32'd0, 16'd20, 1'b0));
        send_seg(mk_seg(48'd0, 48'd0, 32'd0, 16'd0, 1'b0));
    endtask

    // base sequence register at both extremes and a random value
    task automatic test_base_seq_register();
        logic [ABS_W-1:0] v;
        write_base_seq(ABS_MAX);
        send_seg(mk_seg(hi_end + 5, hi_end + 50, ABS_MAX - 32'd10, 16'd7, 1'b1));
        send_seg(mk_seg(hi_end + 5, hi_end + 50, ABS_MAX, 16'd0, 1'b1));
        write_base_seq('0);
        send_seg(mk_seg(hi_end + 9, hi_end + 90, 32'd3, 16'd30, 1'b1));
        v = $urandom;
        write_base_seq(v);
        send_seg(mk_seg(hi_end + 2, hi_end + 20, near_base(-10), 16'd12, 1'b1));
        send_seg(mk_seg(hi_end + 1, hi_end + 20, near_base(10), 16'd25, 1'b1));
    endtask

    task automatic test_random_open(input int unsigned n);
        logic [ABS_W-1:0] v;
        for (int unsigned i = 0; i < n; i++) begin
            if (i % 100 == 0)
                pick_idling();
            if (i % 250 == 249) begin
                case ($urandom_range(0, 3))
                    0:       v = '0;
                    1:       v = ABS_MAX;
                    default: v = $urandom;
                endcase
                write_base_seq(v);
            end
            send_seg(gen_open_seg());
        end
    endtask

    // bundles from zero against an end near half the space saturate redundant bytes
    task automatic test_redundant_saturation();
        send_seg(mk_seg('0, SEQ_HALF, $urandom, PAY_W'($urandom_range(1, 65535)), 1'b0));
        send_seg(mk_seg('0, SEQ_HALF + 1, $urandom, PAY_W'($urandom_range(1, 65535)), 1'b0));
        send_seg(mk_seg('0, SEQ_HALF + 2, $urandom, PAY_W'($urandom_range(1, 65535)), 1'b0));
    endtask

    // syn just outside the window closes the stream; later jumps are ignored
    task automatic test_stream_close();
        logic [ABS_W-1:0] far_abs;
        far_abs = (base_seq <= ABS_MAX - 32'd11) ? base_seq + 32'd11 : base_seq - 32'd11;
        send_seg(mk_seg(hi_end + 3, hi_end + 40, far_abs, 16'd38, 1'b1));
        send_seg(mk_seg(hi_end + 7, hi_end + 70, $urandom, 16'd64, 1'b0));
        send_seg(mk_seg(hi_end + 7, hi_end + 70, base_seq, 16'd64, 1'b1));
        send_seg(mk_seg('0, hi_end + 1, $urandom, 16'd0, 1'b0));
        send_seg(mk_seg(hi_end + 1, hi_end + 30, $urandom, 16'd30, 1'b0));
        send_seg(mk_seg(hi_end - 10, hi_end, $urandom, 16'd11, 1'b0));
        send_seg(mk_seg(hi_end + 1, hi_end - 4, $urandom, 16'd4, 1'b0));
        send_seg(mk_seg(hi_end + 1, hi_end + 60, $urandom, 16'd60, 1'b1));
    endtask

    task automatic test_random_closed(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if (i + 150 >= n) begin
                in_idle_en  = 1'b0;
                out_idle_en = 1'b0;
            end else if (i % 100 == 0) begin
                pick_idling();
            end
            send_seg(gen_closed_seg());
        end
    endtask

    // in-order bundle up to the top of the sequence space saturates new bytes
    task automatic test_new_bytes_saturation();
        send_seg(mk_seg(hi_end + 1, hi_end, $urandom, 16'd9, 1'b0));
        send_seg(mk_seg(hi_end + 1, SEQ_MAX, $urandom, PAY_W'($urandom_range(1, 65535)), 1'b0));
        send_seg(mk_seg(SEQ_MAX, SEQ_MAX, ABS_MAX, 16'hFFFF, 1'b1));
        send_seg(mk_seg(SEQ_MAX, SEQ_MAX, '0, 16'd0, 1'b0));
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_wr_en          = 1'b0;
        i_cfg_wr_data        = '0;
        i_valid              = 1'b0;
        i_seg_start          = '0;
        i_seg_end            = '0;
        i_seg_start_absolute = '0;
        i_payload_bytes      = '0;
        i_syn_flag           = 1'b0;
        in_idle_en           = 1'b1;
        out_idle_en          = 1'b1;
        err_count            = 0;

        hi_end        = '0;
        prev_start    = '0;
        base_seq      = '0;
        stream_closed = 1'b0;
        n_seen        = '0;
        n_data        = '0;
        n_retx        = '0;
        n_bundle      = '0;
        n_ignored     = '0;
        b_total       = '0;
        b_new         = '0;
        b_redund      = '0;
        b_retx        = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_classes();
        test_base_seq_register();
        test_random_open(1400);
        test_redundant_saturation();
        test_stream_close();
        test_random_closed(500);
        test_new_bytes_saturation();
        drain();

        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
